// ----- design/frt_pkg.sv -----
// frt_pkg: shared types and constants of the fragment reassembly tracker
// holds request/result structs, status and command codes, register indexes
// no dependencies
package frt_pkg;

    localparam int SLOTS_DEF    = 16;
    localparam int MAX_FRAG_DEF = 64;

    localparam int CFG_IDX_W = 8;

    localparam logic [31:0] MAX_BYTES_RST = 32'd65535;
    localparam logic [31:0] TIMEOUT_RST   = 32'd5000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_BYTES = 8'd0,
        CFG_TIMEOUT   = 8'd1
    } t_cfg_reg;

    typedef enum logic {
        CMD_FRAGMENT = 1'b0,
        CMD_SWEEP    = 1'b1
    } t_cmd;

    typedef enum logic [3:0] {
        ST_INCOMPLETE   = 4'd0,
        ST_DUPLICATE    = 4'd1,
        ST_COMPLETE     = 4'd2,
        ST_BAD_INDEX    = 4'd3,
        ST_TOO_LARGE    = 4'd4,
        ST_MISMATCH     = 4'd5,
        ST_LEN_MISMATCH = 4'd6,
        ST_TABLE_FULL   = 4'd7,
        ST_TOO_MANY     = 4'd8,
        ST_SWEEP        = 4'd9
    } t_status;

    typedef struct packed {
        logic               command;
        logic [31:0]        message_id;
        logic [7:0]         fragment_index;
        logic [7:0]         fragment_total;
        logic [31:0]        message_length;
        logic [15:0]        chunk_length;
        logic signed [63:0] time_now;
    } t_req;

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] result_message_id;
        logic [31:0] result_length;
        logic [4:0]  expired_count;
    } t_result;

endpackage

// ----- design/fragment_reassembly_tracker.sv -----
// a fragment rejected on index, count or size gives its result in the cycle after start;
// otherwise every slot entry is read once through the entry memory read port and checked in
// the compare stage; a sweep or table-full result follows the scan, a slot update passes
// S_UPDATE first. busy stays high meanwhile; the next request is taken in the cycle the result shows.
// reset (synchronous, active low) clears all slot valid bits and loads the register
// defaults; the entry memory itself is not cleared. results cannot be held off.
module fragment_reassembly_tracker
    import frt_pkg::*;
#(
    parameter int SLOTS         = SLOTS_DEF,
    parameter int MAX_FRAGMENTS = MAX_FRAG_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  t_req                 i_req,
    output logic                 busy,
    output logic                 o_result_strobe,
    output t_result              o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int TW = $clog2(MAX_FRAGMENTS + 1);

    typedef struct packed {
        logic [31:0]              msg_id;
        logic [TW-1:0]            frag_total;
        logic [31:0]              msg_len;
        logic signed [63:0]       start_time;
        logic [MAX_FRAGMENTS-1:0] rx_map;
        logic [31:0]              byte_sum;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_UPDATE = 3'b100
    } t_state;

    t_state          r_state;
    t_req            r_req;
    logic [CW-1:0]   r_scan_cnt;
    logic            r_cmp_vld;
    logic [AW-1:0]   r_cmp_idx;
    t_entry          r_rd_data;
    t_entry          r_mem [SLOTS];
    logic [SLOTS-1:0] r_valid;
    logic            r_hit_found;
    logic [AW-1:0]   r_hit_idx;
    logic            r_free_found;
    logic [AW-1:0]   r_free_idx;
    t_entry          r_ent;
    logic [4:0]      r_freed;
    logic [31:0]     r_max_bytes;
    logic [31:0]     r_timeout;
    logic            r_out_vld;
    t_result         r_out;

    logic            scan_issue;
    logic            scan_done;
    logic signed [64:0] age;
    logic            aged_out;
    logic            id_hit;

    t_entry                   ent_cur;
    t_entry                   ent_upd;
    logic [MAX_FRAGMENTS-1:0] frag_bit;
    logic [MAX_FRAGMENTS-1:0] full_mask;
    logic                     meta_diff;
    logic                     dup;
    logic                     all_in;
    logic [AW-1:0]            tgt_idx;

    logic            accept;
    logic            early_bad_idx;
    logic            early_too_many;
    logic            early_too_large;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    assign o_result_strobe = r_out_vld;
    assign o_result        = r_out;

    assign early_bad_idx   = (i_req.fragment_total == 8'd0) ||
                             (i_req.fragment_index >= i_req.fragment_total);
    assign early_too_many  = (i_req.fragment_total > 8'(MAX_FRAGMENTS));
    assign early_too_large = (i_req.message_length > r_max_bytes);

    assign scan_issue = (r_state == S_SCAN) && (r_scan_cnt != CW'(SLOTS));
    assign scan_done  = (r_state == S_SCAN) && (r_scan_cnt == CW'(SLOTS)) && !r_cmp_vld;

    // shared compare unit: id match for fragments, signed 65-bit age test for sweeps
    always_comb begin
        age      = {r_req.time_now[63], r_req.time_now} -
                   {r_rd_data.start_time[63], r_rd_data.start_time};
        aged_out = (age > $signed({33'd0, r_timeout}));
        id_hit   = (r_rd_data.msg_id == r_req.message_id);
    end

    // slot update path
    always_comb begin
        for (int i = 0; i < MAX_FRAGMENTS; i++) begin
            frag_bit[i]  = (r_req.fragment_index == 8'(i));
            full_mask[i] = (8'(i) < r_req.fragment_total);
        end
        if (r_hit_found) begin
            ent_cur = r_ent;
        end else begin
            ent_cur.msg_id     = r_req.message_id;
            ent_cur.frag_total = TW'(r_req.fragment_total);
            ent_cur.msg_len    = r_req.message_length;
            ent_cur.start_time = r_req.time_now;
            ent_cur.rx_map     = '0;
            ent_cur.byte_sum   = '0;
        end
        meta_diff = (8'(ent_cur.frag_total) != r_req.fragment_total) ||
                    (ent_cur.msg_len != r_req.message_length);
        dup       = |(ent_cur.rx_map & frag_bit);
        ent_upd          = ent_cur;
        ent_upd.rx_map   = ent_cur.rx_map | frag_bit;
        ent_upd.byte_sum = ent_cur.byte_sum + 32'(r_req.chunk_length);
        all_in    = ((ent_upd.rx_map & full_mask) == full_mask);
        tgt_idx   = r_hit_found ? r_hit_idx : r_free_idx;
    end

    // entry memory: one read and one write port
    always_ff @(posedge i_clk) begin
        if (scan_issue) begin
            r_rd_data <= r_mem[r_scan_cnt[AW-1:0]];
        end
        if ((r_state == S_UPDATE) && !meta_diff && !dup) begin
            r_mem[tgt_idx] <= (r_req.chunk_length == 16'd0) ? ent_cur : ent_upd;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= MAX_BYTES_RST;
            r_timeout   <= TIMEOUT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_MAX_BYTES) begin
                r_max_bytes <= i_cfg_data;
            end
            if (i_cfg_index == CFG_TIMEOUT) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_out_vld    <= 1'b0;
            r_cmp_vld    <= 1'b0;
            r_scan_cnt   <= '0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_freed      <= '0;
        end else begin
            r_out_vld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_req                   <= i_req;
                        r_scan_cnt              <= '0;
                        r_cmp_vld               <= 1'b0;
                        r_hit_found             <= 1'b0;
                        r_free_found            <= 1'b0;
                        r_freed                 <= '0;
                        r_out.result_message_id <= i_req.message_id;
                        r_out.result_length     <= '0;
                        r_out.expired_count     <= '0;
                        if (i_req.command == CMD_SWEEP) begin
                            r_state <= S_SCAN;
                        end else if (early_bad_idx) begin
                            r_out_vld    <= 1'b1;
                            r_out.status <= ST_BAD_INDEX;
                        end else if (early_too_many) begin
                            r_out_vld    <= 1'b1;
                            r_out.status <= ST_TOO_MANY;
                        end else if (early_too_large) begin
                            r_out_vld    <= 1'b1;
                            r_out.status <= ST_TOO_LARGE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_cmp_vld <= scan_issue;
                    if (scan_issue) begin
                        r_cmp_idx  <= r_scan_cnt[AW-1:0];
                        r_scan_cnt <= r_scan_cnt + 1'b1;
                    end
                    // compare stage works on the entry read in the previous cycle
                    if (r_cmp_vld) begin
                        if (r_req.command == CMD_SWEEP) begin
                            if (r_valid[r_cmp_idx] && aged_out) begin
                                r_valid[r_cmp_idx] <= 1'b0;
                                if (r_freed != 5'd31) begin
                                    r_freed <= r_freed + 5'd1;
                                end
                            end
                        end else if (r_valid[r_cmp_idx]) begin
                            if (!r_hit_found && id_hit) begin
                                r_hit_found <= 1'b1;
                                r_hit_idx   <= r_cmp_idx;
                                r_ent       <= r_rd_data;
                            end
                        end else if (!r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= r_cmp_idx;
                        end
                    end
                    if (scan_done) begin
                        if (r_req.command == CMD_SWEEP) begin
                            r_state                 <= S_IDLE;
                            r_out_vld               <= 1'b1;
                            r_out.status            <= ST_SWEEP;
                            r_out.result_message_id <= '0;
                            r_out.expired_count     <= r_freed;
                        end else if (!r_hit_found && !r_free_found) begin
                            r_state      <= S_IDLE;
                            r_out_vld    <= 1'b1;
                            r_out.status <= ST_TABLE_FULL;
                        end else begin
                            r_state <= S_UPDATE;
                        end
                    end
                end
                S_UPDATE: begin
                    r_state   <= S_IDLE;
                    r_out_vld <= 1'b1;
                    if (meta_diff) begin
                        r_out.status <= ST_MISMATCH;
                    end else if (dup) begin
                        r_out.status <= ST_DUPLICATE;
                    end else if (r_req.chunk_length == 16'd0) begin
                        r_valid[tgt_idx] <= 1'b1;
                        r_out.status     <= ST_INCOMPLETE;
                    end else if (!all_in) begin
                        r_valid[tgt_idx] <= 1'b1;
                        r_out.status     <= ST_INCOMPLETE;
                    end else if (ent_upd.byte_sum != r_req.message_length) begin
                        r_valid[tgt_idx] <= 1'b1;
                        r_out.status     <= ST_LEN_MISMATCH;
                    end else begin
                        r_valid[tgt_idx]    <= 1'b0;
                        r_out.status        <= ST_COMPLETE;
                        r_out.result_length <= r_req.message_length;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_sweep_not_immediate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req.command == CMD_SWEEP)) |=> !o_result_strobe)
        else $error("sweep result came without a slot scan");

    a_strobe_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> ($past(busy) || $past(start)))
        else $error("result strobe without a request in work");

    a_update_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) |-> (r_hit_found || r_free_found))
        else $error("slot update entered with no target slot");

endmodule
